// File: hdl/hdc_am_pkg.sv
// Shared types and constants for the associative-memory classifier.
// No dependencies; every other file of the block but hdc_am_mem imports this package.
package hdc_am_pkg;

  localparam int CNT_W     = 16;
  localparam int SCORE_W   = 27;
  localparam int OUT_CLS_W = 3;
  localparam int LABEL_W   = 4;
  localparam int CHUNK_W   = 7;
  localparam int HV_W      = 8;

  localparam logic signed [CNT_W-1:0]   CNT_MAX   = 16'sh7FFF;
  localparam logic signed [CNT_W-1:0]   CNT_MIN   = 16'sh8000;
  localparam logic signed [SCORE_W-1:0] SCORE_MAX = 27'sh3FFFFFF;
  localparam logic signed [SCORE_W-1:0] SCORE_MIN = 27'sh4000000;

  localparam logic OP_QUERY = 1'b0;
  localparam logic OP_TRAIN = 1'b1;

  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_TRD,
    ST_TWR,
    ST_QRD,
    ST_QDRAIN,
    ST_EMIT
  } state_t;

  // Controller to scoring pipeline.
  typedef struct packed {
    logic               issue;    // a class row read was issued this cycle
    logic               restart;  // chunk 0: start the score from zero
    logic [LABEL_W-1:0] cls;      // class of the issued row
    logic               emit;     // load the winner into the output register
  } score_ctl_t;

  // Scoring pipeline to controller.
  typedef struct packed {
    logic busy;    // rows still in flight
    logic out_ok;  // output register can take a result this cycle
  } score_sts_t;

endpackage

// File: hdl/hdc_am_mem.sv
// Single-port-write, single-port-read synchronous RAM holding the class counters.
// Read data is registered. Uses no package items.
module hdc_am_mem #(
  parameter int AW = 10,
  parameter int DW = 128
) (
  input  logic          clk,
  input  logic          rd_en,
  input  logic [AW-1:0] rd_addr,
  input  logic          wr_en,
  input  logic [AW-1:0] wr_addr,
  input  logic [DW-1:0] wr_data,
  output logic [DW-1:0] rd_data
);

  logic [DW-1:0] mem [2**AW];
  logic [DW-1:0] rd_data_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data_r <= mem[rd_addr];
    end
  end

  assign rd_data = rd_data_r;

endmodule

// File: hdl/hdc_am_ctrl.sv
// Sequencer: accepts requests, clears the counter RAM after reset, runs the
// train read-modify-write and issues one class row read per cycle for queries.
// Depends on hdc_am_pkg.
module hdc_am_ctrl #(
  parameter int DIM     = 1024,
  parameter int CLASSES = 8,
  parameter int LANES   = 8,
  parameter int CLS_W   = 3,
  parameter int CHK_AW  = 7
) (
  input  logic                                 clk,
  input  logic                                 rst_n,
  input  logic                                 in_tvalid,
  output logic                                 in_tready,
  input  logic                                 in_op,
  input  logic [hdc_am_pkg::LABEL_W-1:0]       in_label,
  input  logic [hdc_am_pkg::CHUNK_W-1:0]       in_chunk,
  input  logic [hdc_am_pkg::HV_W-1:0]          in_hv,
  input  logic [LANES*hdc_am_pkg::CNT_W-1:0]   rd_data,
  input  hdc_am_pkg::score_sts_t               sts,
  output hdc_am_pkg::score_ctl_t               ctl,
  output logic [LANES-1:0]                     lane_sign,
  output logic [LANES-1:0]                     lane_ok,
  output logic                                 rd_en,
  output logic [CLS_W+CHK_AW-1:0]              rd_addr,
  output logic                                 wr_en,
  output logic [CLS_W+CHK_AW-1:0]              wr_addr,
  output logic [LANES*hdc_am_pkg::CNT_W-1:0]   wr_data
);
  import hdc_am_pkg::*;

  localparam int CHUNKS     = (DIM + LANES - 1) / LANES;
  localparam int LAST_CHUNK = CHUNKS - 1;
  localparam int REM        = DIM % LANES;
  localparam int AW         = CLS_W + CHK_AW;

  state_t             state_r, state_nxt;
  logic [CLS_W-1:0]   cls_r, cls_nxt;
  logic [AW-1:0]      clr_r, clr_nxt;
  logic [LABEL_W-1:0] label_r;
  logic [CHUNK_W-1:0] chunk_r;
  logic [HV_W-1:0]    hv_r;

  logic              accept;
  logic              chunk_ok;
  logic              label_ok;
  logic              is_last;
  logic              cls_last;
  logic [CHK_AW-1:0] chunk_a;
  logic [AW-1:0]     train_addr;
  logic [AW-1:0]     query_addr;

  assign accept   = in_tvalid && in_tready;
  assign chunk_ok = int'(in_chunk) < CHUNKS;
  assign label_ok = int'(in_label) < CLASSES;
  assign is_last  = int'(chunk_r) == LAST_CHUNK;
  assign cls_last = cls_r == CLS_W'(CLASSES - 1);

  // Chunk numbers below CHUNKS always fit in CHK_AW bits.
  assign chunk_a    = CHK_AW'(chunk_r);
  assign train_addr = {label_r[CLS_W-1:0], chunk_a};
  assign query_addr = {cls_r, chunk_a};

  // Lanes past the 8-bit field count as -1; lanes past DIM are skipped.
  for (genvar j = 0; j < LANES; j++) begin : g_lane
    if (j < HV_W) begin : g_bit
      assign lane_sign[j] = hv_r[j];
    end else begin : g_pad
      assign lane_sign[j] = 1'b0;
    end
    assign lane_ok[j] = !(is_last && (REM != 0) && (j >= REM));
  end

  // Saturating +/-1 on each counter of the row being trained.
  for (genvar j = 0; j < LANES; j++) begin : g_train
    logic signed [CNT_W-1:0] cnt;
    logic signed [CNT_W-1:0] upd;
    assign cnt = $signed(rd_data[j*CNT_W +: CNT_W]);
    always_comb begin
      upd = cnt;
      if (lane_ok[j]) begin
        if (lane_sign[j]) begin
          if (cnt != CNT_MAX) upd = cnt + 16'sd1;
        end else begin
          if (cnt != CNT_MIN) upd = cnt - 16'sd1;
        end
      end
    end
    assign wr_data[j*CNT_W +: CNT_W] = (state_r == ST_CLEAR) ? '0 : upd;
  end

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_CLEAR: begin
        if (clr_r == '1) state_nxt = ST_IDLE;
      end
      ST_IDLE: begin
        if (in_tvalid && chunk_ok) begin
          if (in_op == OP_TRAIN) begin
            if (label_ok) state_nxt = ST_TRD;
          end else begin
            state_nxt = ST_QRD;
          end
        end
      end
      ST_TRD:    state_nxt = ST_TWR;
      ST_TWR:    state_nxt = ST_IDLE;
      ST_QRD: begin
        if (cls_last) state_nxt = ST_QDRAIN;
      end
      ST_QDRAIN: begin
        if (!sts.busy) state_nxt = is_last ? ST_EMIT : ST_IDLE;
      end
      ST_EMIT: begin
        if (sts.out_ok) state_nxt = ST_IDLE;
      end
      default:   state_nxt = ST_IDLE;
    endcase
  end

  always_comb begin
    in_tready   = 1'b0;
    rd_en       = 1'b0;
    rd_addr     = query_addr;
    wr_en       = 1'b0;
    wr_addr     = train_addr;
    ctl.issue   = 1'b0;
    ctl.restart = chunk_r == '0;
    ctl.cls     = LABEL_W'(cls_r);
    ctl.emit    = 1'b0;
    case (state_r)
      ST_CLEAR: begin
        wr_en   = 1'b1;
        wr_addr = clr_r;
      end
      ST_IDLE:   in_tready = 1'b1;
      ST_TRD: begin
        rd_en   = 1'b1;
        rd_addr = train_addr;
      end
      ST_TWR:    wr_en = 1'b1;
      ST_QRD: begin
        rd_en     = 1'b1;
        ctl.issue = 1'b1;
      end
      ST_QDRAIN: ;
      ST_EMIT:   ctl.emit = sts.out_ok;
      default:   ;
    endcase
  end

  always_comb begin
    cls_nxt = cls_r;
    clr_nxt = clr_r;
    if (state_r == ST_CLEAR) clr_nxt = clr_r + 1'b1;
    if (accept) begin
      cls_nxt = '0;
    end else if (state_r == ST_QRD) begin
      cls_nxt = cls_r + 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_CLEAR;
      cls_r   <= '0;
      clr_r   <= '0;
    end else begin
      state_r <= state_nxt;
      cls_r   <= cls_nxt;
      clr_r   <= clr_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      label_r <= in_label;
      chunk_r <= in_chunk;
      hv_r    <= in_hv;
    end
  end

endmodule

// File: hdl/hdc_am_score.sv
// Query datapath: per-row dot product, saturating running scores, running
// argmax and the output register. Depends on hdc_am_pkg.
module hdc_am_score #(
  parameter int CLASSES = 8,
  parameter int LANES   = 8,
  parameter int CLS_W   = 3
) (
  input  logic                                      clk,
  input  logic                                      rst_n,
  input  hdc_am_pkg::score_ctl_t                    ctl,
  input  logic [LANES-1:0]                          lane_sign,
  input  logic [LANES-1:0]                          lane_ok,
  input  logic [LANES*hdc_am_pkg::CNT_W-1:0]        rd_data,
  output hdc_am_pkg::score_sts_t                    sts,
  output logic                                      out_tvalid,
  input  logic                                      out_tready,
  output logic [hdc_am_pkg::OUT_CLS_W-1:0]          out_class,
  output logic signed [hdc_am_pkg::SCORE_W-1:0]     out_score
);
  import hdc_am_pkg::*;

  localparam int PART_W = CNT_W + $clog2(LANES) + 1;
  localparam int SUM_W  = SCORE_W + 1;

  localparam logic signed [SUM_W-1:0] SUM_MAX = SUM_W'(SCORE_MAX);
  localparam logic signed [SUM_W-1:0] SUM_MIN = SUM_W'(SCORE_MIN);

  // Stage 1: row data arrives from the RAM.
  logic             v1_r, rst1_r;
  logic [CLS_W-1:0] cls1_r;
  // Stage 2: partial dot product of the row.
  logic                     v2_r, rst2_r;
  logic [CLS_W-1:0]         cls2_r;
  logic signed [PART_W-1:0] part_r;
  // Stage 3: updated score, compared against the best so far.
  logic                      v3_r;
  logic [CLS_W-1:0]          cls3_r;
  logic signed [SCORE_W-1:0] sc3_r;

  logic signed [SCORE_W-1:0] scores_r [CLASSES];
  logic signed [SCORE_W-1:0] best_sc_r;
  logic [CLS_W-1:0]          best_idx_r;

  logic                      out_valid_r;
  logic [OUT_CLS_W-1:0]      out_class_r;
  logic signed [SCORE_W-1:0] out_score_r;

  logic signed [PART_W-1:0]  part;
  logic signed [SUM_W-1:0]   sum;
  logic signed [SCORE_W-1:0] old_sc;
  logic signed [SCORE_W-1:0] new_sc;

  always_comb begin
    logic signed [PART_W-1:0] term;
    part = '0;
    for (int j = 0; j < LANES; j++) begin
      term = PART_W'($signed(rd_data[j*CNT_W +: CNT_W]));
      if (!lane_ok[j]) begin
        term = '0;
      end else if (!lane_sign[j]) begin
        term = -term;
      end
      part = part + term;
    end
  end

  assign old_sc = rst2_r ? '0 : scores_r[cls2_r];
  assign sum    = SUM_W'(old_sc) + SUM_W'(part_r);

  always_comb begin
    if (sum > SUM_MAX) begin
      new_sc = SCORE_MAX;
    end else if (sum < SUM_MIN) begin
      new_sc = SCORE_MIN;
    end else begin
      new_sc = SCORE_W'(sum);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
      v2_r <= 1'b0;
      v3_r <= 1'b0;
      for (int c = 0; c < CLASSES; c++) scores_r[c] <= '0;
    end else begin
      v1_r <= ctl.issue;
      v2_r <= v1_r;
      v3_r <= v2_r;
      if (v2_r) scores_r[cls2_r] <= new_sc;
    end
  end

  always_ff @(posedge clk) begin
    rst1_r <= ctl.restart;
    cls1_r <= ctl.cls[CLS_W-1:0];
    rst2_r <= rst1_r;
    cls2_r <= cls1_r;
    part_r <= part;
    cls3_r <= cls2_r;
    sc3_r  <= new_sc;
  end

  // Classes come in ascending order, so a strict compare keeps the lowest
  // index on ties; class 0 always seeds the search.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      best_sc_r  <= '0;
      best_idx_r <= '0;
    end else if (v3_r && (cls3_r == '0 || sc3_r > best_sc_r)) begin
      best_sc_r  <= sc3_r;
      best_idx_r <= cls3_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (ctl.emit) begin
      out_valid_r <= 1'b1;
    end else if (out_tready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.emit) begin
      out_class_r <= OUT_CLS_W'(best_idx_r);
      out_score_r <= best_sc_r;
    end
  end

  assign sts.busy   = v1_r || v2_r || v3_r;
  assign sts.out_ok = !out_valid_r || out_tready;
  assign out_tvalid = out_valid_r;
  assign out_class  = out_class_r;
  assign out_score  = out_score_r;

endmodule

// File: hdl/hdc_associative_memory_top.sv
// Top level of the hyperdimensional associative-memory classifier.
// Depends on hdc_am_pkg, hdc_am_mem, hdc_am_ctrl and hdc_am_score.
//
//   Channel  Dir  Payload
//   in_      in   tuser = operation; tdata = class_label, chunk_index, hv_bits
//   out_     out  tdata = predicted_class, top_score
//
// A train request passes through accept, counter row read and write-back.
// A query request is accepted, then the counter RAM delivers one class row per
// cycle from its registered read port, the score pipeline (three stages deep)
// drains, and on the last chunk the winner is loaded into the output register.
// After reset the RAM is cleared one row per cycle over its whole address range
// (1024 rows at the default sizes) while in_tready stays low. While a result
// waits in the output register, the next last-chunk query holds in its final
// step until out_tready rises.
module hdc_associative_memory_top #(
  parameter int DIM     = 1024,
  parameter int CLASSES = 8,
  parameter int LANES   = 8
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [0:0]  in_tuser,   // [0] operation
  input  logic [23:0] in_tdata,   // [3:0] class_label, [10:4] chunk_index, [18:11] hv_bits
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [31:0] out_tdata   // [2:0] predicted_class, [29:3] top_score
);
  import hdc_am_pkg::*;

  localparam int CHUNKS = (DIM + LANES - 1) / LANES;
  localparam int CLS_W  = $clog2(CLASSES);
  localparam int CHK_AW = (CHUNKS > 1) ? $clog2(CHUNKS) : 1;
  localparam int AW     = CLS_W + CHK_AW;
  localparam int DW     = LANES * CNT_W;

  score_ctl_t ctl;
  score_sts_t sts;

  logic [LANES-1:0] lane_sign;
  logic [LANES-1:0] lane_ok;
  logic             rd_en;
  logic [AW-1:0]    rd_addr;
  logic             wr_en;
  logic [AW-1:0]    wr_addr;
  logic [DW-1:0]    wr_data;
  logic [DW-1:0]    rd_data;

  logic [OUT_CLS_W-1:0]      out_class;
  logic signed [SCORE_W-1:0] out_score;

  hdc_am_ctrl #(
    .DIM     (DIM),
    .CLASSES (CLASSES),
    .LANES   (LANES),
    .CLS_W   (CLS_W),
    .CHK_AW  (CHK_AW)
  ) u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_op     (in_tuser[0]),
    .in_label  (in_tdata[3:0]),
    .in_chunk  (in_tdata[10:4]),
    .in_hv     (in_tdata[18:11]),
    .rd_data   (rd_data),
    .sts       (sts),
    .ctl       (ctl),
    .lane_sign (lane_sign),
    .lane_ok   (lane_ok),
    .rd_en     (rd_en),
    .rd_addr   (rd_addr),
    .wr_en     (wr_en),
    .wr_addr   (wr_addr),
    .wr_data   (wr_data)
  );

  hdc_am_mem #(
    .AW (AW),
    .DW (DW)
  ) u_mem (
    .clk     (clk),
    .rd_en   (rd_en),
    .rd_addr (rd_addr),
    .wr_en   (wr_en),
    .wr_addr (wr_addr),
    .wr_data (wr_data),
    .rd_data (rd_data)
  );

  hdc_am_score #(
    .CLASSES (CLASSES),
    .LANES   (LANES),
    .CLS_W   (CLS_W)
  ) u_score (
    .clk        (clk),
    .rst_n      (rst_n),
    .ctl        (ctl),
    .lane_sign  (lane_sign),
    .lane_ok    (lane_ok),
    .rd_data    (rd_data),
    .sts        (sts),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_class  (out_class),
    .out_score  (out_score)
  );

  // Bits 23:19 of in_tdata are padding.
  logic unused_pad;
  assign unused_pad = ^in_tdata[23:19];

  assign out_tdata = {2'b00, out_score, out_class};

`ifndef SYNTHESIS
  // The counter RAM is never written while query rows are still in flight.
  a_no_write_in_query: assert property (@(posedge clk) disable iff (!rst_n)
    wr_en |-> !sts.busy)
    else $error("counter write during query pipeline activity");

  // A new request is only taken once the score pipeline has drained.
  a_ready_idle: assert property (@(posedge clk) disable iff (!rst_n)
    in_tready |-> !sts.busy)
    else $error("request accepted with score pipeline busy");

  // A result is loaded only when the output register is free or being emptied.
  a_emit_room: assert property (@(posedge clk) disable iff (!rst_n)
    ctl.emit |-> (!out_tvalid || out_tready))
    else $error("result would overwrite a pending result");

  // No row reads are issued while the output is being loaded.
  a_emit_quiet: assert property (@(posedge clk) disable iff (!rst_n)
    ctl.emit |-> !ctl.issue && !sts.busy)
    else $error("result loaded while query rows are in flight");
`endif

endmodule

// File: tb/testbench.sv
// Self-checking testbench for hdc_associative_memory_top at its default sizes.
// Depends on hdc_am_pkg and the block's RTL; a scoreboard class predicts every
// winner, and plain tasks drive requests with random idling on both channels.
module testbench;
  import hdc_am_pkg::*;

  localparam int DIM            = 1024;
  localparam int CLASSES        = 8;
  localparam int LANES          = 8;
  localparam int CHUNKS         = (DIM + LANES - 1) / LANES;
  localparam int LAST_CHUNK     = CHUNKS - 1;
  localparam int RANDOM_ITEMS   = 600;
  localparam int ROW_REPEATS    = 20;
  localparam int WATCHDOG_LIMIT = 4000;
  localparam int DRAIN_CYCLES   = 20;

  typedef struct {
    logic [OUT_CLS_W-1:0]      cls;
    logic signed [SCORE_W-1:0] score;
  } winner_t;

  class hdc_scoreboard;
    logic signed [CNT_W-1:0]   class_rows [CLASSES][DIM];
    logic signed [SCORE_W-1:0] scores [CLASSES];
    winner_t                   pending_winners [$];
    int                        errors;

    function new();
      foreach (class_rows[c, e]) class_rows[c][e] = '0;
      foreach (scores[c]) scores[c] = '0;
      errors = 0;
    endfunction

    // Applies one accepted request to the counter rows and running scores.
    function void note_request(logic op, logic [LABEL_W-1:0] label,
                               logic [CHUNK_W-1:0] chunk, logic [HV_W-1:0] hv);
      int      base, e, j, c, acc, part, best_idx;
      winner_t w;
      base = int'(chunk) * LANES;
      if (base >= DIM) return;
      if (op == OP_TRAIN) begin
        if (int'(label) >= CLASSES) return;
        for (j = 0; j < LANES; j++) begin
          e = base + j;
          if (e >= DIM) break;
          acc = int'(class_rows[label][e]) + ((j < HV_W && hv[j]) ? 1 : -1);
          if (acc > CNT_MAX) acc = CNT_MAX;
          if (acc < CNT_MIN) acc = CNT_MIN;
          class_rows[label][e] = acc[CNT_W-1:0];
        end
        return;
      end
      if (chunk == '0) foreach (scores[k]) scores[k] = '0;
      for (c = 0; c < CLASSES; c++) begin
        part = 0;
        for (j = 0; j < LANES; j++) begin
          e = base + j;
          if (e >= DIM) break;
          if (j < HV_W && hv[j]) part += int'(class_rows[c][e]);
          else part -= int'(class_rows[c][e]);
        end
        acc = int'(scores[c]) + part;
        if (acc > SCORE_MAX) acc = SCORE_MAX;
        if (acc < SCORE_MIN) acc = SCORE_MIN;
        scores[c] = acc[SCORE_W-1:0];
      end
      if (int'(chunk) == LAST_CHUNK) begin
        best_idx = 0;
        for (c = 1; c < CLASSES; c++)
          if (scores[c] > scores[best_idx]) best_idx = c;
        w.cls   = best_idx[OUT_CLS_W-1:0];
        w.score = scores[best_idx];
        pending_winners.push_back(w);
      end
    endfunction

    function void check_result(logic [OUT_CLS_W-1:0] cls, logic signed [SCORE_W-1:0] score);
      winner_t w;
      if (pending_winners.size() == 0) begin
        $error("unexpected result: predicted_class %0d top_score %0d", cls, score);
        errors++;
        return;
      end
      w = pending_winners.pop_front();
      if (cls !== w.cls) begin
        $error("predicted_class: expected %0d, actual %0d", w.cls, cls);
        errors++;
      end
      if (score !== w.score) begin
        $error("top_score: expected %0d, actual %0d", w.score, score);
        errors++;
      end
    endfunction
  endclass

  logic        clk        = 1'b0;
  logic        rst_n      = 1'b0;
  logic        in_tvalid  = 1'b0;
  logic        in_tready;
  logic [0:0]  in_tuser   = '0;   // [0] operation
  logic [23:0] in_tdata   = '0;   // [3:0] class_label, [10:4] chunk_index, [18:11] hv_bits
  logic        out_tvalid;
  logic        out_tready = 1'b0;
  logic [31:0] out_tdata;         // [2:0] predicted_class, [29:3] top_score

  hdc_scoreboard      sb;
  logic [HV_W-1:0]    proto [CLASSES][CHUNKS];
  bit                 calm = 1'b0;
  int                 requests_sent = 0;
  int                 quiet_cycles = 0;

  hdc_associative_memory_top i_dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tuser   (in_tuser),
    .in_tdata   (in_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  always @(posedge clk) begin
    if (calm) out_tready <= 1'b1;
    else out_tready <= ($urandom_range(0, 9) != 0);
  end

  // Result checking and the watchdog on cycles in which nothing moves.
  always @(posedge clk) begin
    if (rst_n && out_tvalid && out_tready)
      sb.check_result(out_tdata[2:0], out_tdata[29:3]);
    if ((in_tvalid && in_tready) || (out_tvalid && out_tready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("== FAIL ==");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  function automatic logic [HV_W-1:0] sparse_noise();
    return 8'($urandom) & 8'($urandom) & 8'($urandom);
  endfunction

  task automatic send_request(input logic op, input logic [LABEL_W-1:0] label,
                              input logic [CHUNK_W-1:0] chunk, input logic [HV_W-1:0] hv);
    if (!calm && $urandom_range(0, 9) == 0) begin
      in_tvalid <= 1'b0;
      repeat ($urandom_range(1, 3)) @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tuser  <= op;
    in_tdata  <= {5'b0, hv, chunk, label};
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    sb.note_request(op, label, chunk, hv);
    requests_sent++;
  endtask

  // A few noisy chunks of one class prototype; now and then the label is out of range.
  task automatic train_burst();
    int                 cls, n, k;
    logic [CHUNK_W-1:0] chunk;
    cls = ($urandom_range(0, 9) == 0) ? $urandom_range(CLASSES, 15) : $urandom_range(0, CLASSES-1);
    n = $urandom_range(1, 8);
    for (k = 0; k < n; k++) begin
      chunk = 7'($urandom_range(0, LAST_CHUNK));
      send_request(OP_TRAIN, cls[3:0], chunk, proto[cls % CLASSES][chunk] ^ sparse_noise());
    end
  endtask

  // A query run ending on the last chunk; short runs pick random middle chunks
  // and sometimes leave out chunk 0 so the old scores carry over.
  task automatic query_pass(input bit full);
    int                 cls, n, k;
    logic [CHUNK_W-1:0] chunk;
    cls = $urandom_range(0, CLASSES-1);
    n = full ? LAST_CHUNK - 1 : $urandom_range(0, 6);
    if (full || $urandom_range(0, 7) != 0)
      send_request(OP_QUERY, 4'($urandom), '0, proto[cls][0] ^ sparse_noise());
    for (k = 1; k <= n; k++) begin
      chunk = full ? 7'(k) : 7'($urandom_range(1, LAST_CHUNK - 1));
      send_request(OP_QUERY, 4'($urandom), chunk, proto[cls][chunk] ^ sparse_noise());
    end
    send_request(OP_QUERY, 4'($urandom), 7'(LAST_CHUNK),
                 proto[cls][LAST_CHUNK] ^ sparse_noise());
  endtask

  initial begin
    int pick, random_start;
    sb = new();
    foreach (proto[c, k]) proto[c][k] = 8'($urandom);
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;

    // Query on the cleared memory: every score ties at zero.
    send_request(OP_QUERY, 4'h0, 7'd0, 8'h00);
    send_request(OP_QUERY, 4'hF, 7'(LAST_CHUNK), 8'hFF);
    send_request(OP_TRAIN, 4'd3, 7'd0, 8'hFF);
    send_request(OP_TRAIN, 4'd3, 7'(LAST_CHUNK), 8'h00);
    send_request(OP_TRAIN, 4'd7, 7'd64, 8'hA5);
    send_request(OP_TRAIN, 4'd0, 7'd1, 8'h5A);
    // Labels at or above the class count are dropped.
    send_request(OP_TRAIN, 4'd8, 7'd0, 8'hFF);
    send_request(OP_TRAIN, 4'hF, 7'(LAST_CHUNK), 8'h5A);
    send_request(OP_QUERY, 4'h0, 7'd0, 8'hFF);
    send_request(OP_QUERY, 4'h8, 7'd64, 8'hA5);
    send_request(OP_QUERY, 4'h0, 7'(LAST_CHUNK), 8'h00);
    // No chunk 0, repeated chunks: scores keep accumulating.
    send_request(OP_QUERY, 4'h1, 7'(LAST_CHUNK), 8'h00);
    send_request(OP_QUERY, 4'h2, 7'd64, 8'h5A);
    send_request(OP_QUERY, 4'h2, 7'd64, 8'h5A);
    send_request(OP_QUERY, 4'h3, 7'(LAST_CHUNK), 8'hFF);
    // Negative scores on classes 0 and 3, so the lowest remaining class wins the tie at zero.
    send_request(OP_QUERY, 4'h0, 7'd0, 8'h00);
    send_request(OP_QUERY, 4'h0, 7'd1, 8'hA5);
    send_request(OP_QUERY, 4'h0, 7'(LAST_CHUNK), 8'hFF);

    random_start = requests_sent;
    while (requests_sent < random_start + RANDOM_ITEMS) begin
      calm = (requests_sent >= random_start + 250 && requests_sent < random_start + 400);
      pick = $urandom_range(0, 19);
      if (pick < 8) train_burst();
      else if (pick < 16) query_pass(1'b0);
      else if (pick == 16) query_pass(1'b1);
      else send_request(1'($urandom), 4'($urandom), 7'($urandom), 8'($urandom));
    end
    calm = 1'b0;

    // Push one row well away from zero in both directions, then query it both ways.
    repeat (ROW_REPEATS) send_request(OP_TRAIN, 4'd5, 7'd9, 8'h0F);
    send_request(OP_QUERY, 4'h0, 7'd0, 8'h3C);
    send_request(OP_QUERY, 4'h0, 7'd9, 8'h0F);
    send_request(OP_QUERY, 4'h0, 7'(LAST_CHUNK), 8'h81);
    send_request(OP_QUERY, 4'h0, 7'd0, 8'hF0);
    send_request(OP_QUERY, 4'h0, 7'd9, 8'hF0);
    send_request(OP_QUERY, 4'h0, 7'(LAST_CHUNK), 8'h00);
    repeat (4) send_request(OP_TRAIN, 4'd5, 7'd9, 8'hF0);
    send_request(OP_QUERY, 4'h0, 7'd0, 8'h00);
    send_request(OP_QUERY, 4'h0, 7'd9, 8'h0F);
    send_request(OP_QUERY, 4'h0, 7'(LAST_CHUNK), 8'hFF);
    in_tvalid <= 1'b0;

    while (sb.pending_winners.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (sb.errors == 0 && sb.pending_winners.size() == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule
